FILE: src/double_ended_queue_macros.svh
// assertion macros for the double-ended queue
// expects signals named clock and reset in the module that uses them
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// condition must hold at every edge outside reset
`define DQ_ASSERT_ALWAYS(lbl, cond, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define DQ_ASSERT_IMPL(lbl, ant, con, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(lbl, ant, con, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) else $error(msg);

`endif

FILE: src/dq_pkg.sv
// package for the double-ended queue: operation and status codes, field widths
// no dependencies

package dq_pkg;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       pop_ok;
      status_type status;
      logic [OCC_W-1:0] occupancy;
   } meta_type;

endpackage

FILE: src/double_ended_queue.sv
// double-ended queue of 32-bit words in a circular buffer memory
// depends on dq_pkg and double_ended_queue_macros.svh
//
//   channel  dir  tdata                                 tuser
//   req      in   value[31:0]                           operation[1:0]
//   rsp      out  removed_value[31:0], occupancy[36:32]  status[1:0]
//
// one item per cycle unless rsp stalls; results pass the read and output registers
// indices and count update at the accept edge, the memory is read or written
// at that same edge, so a pop right after a push sees the pushed word
// the memory read register and the output register make the two stages
// synchronous reset empties the queue; memory contents are not cleared
// a stalled rsp holds its item, and req stalls while both stages are held

module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // removed_value[31:0], occupancy[36:32], zeros
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [dq_pkg::WORD_W-1:0] mem [DEPTH];
   logic [dq_pkg::WORD_W-1:0] rd_ff;

   logic [IDX_W-1:0] front_ff, front_in, rear_ff, rear_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic              s1_valid_ff, s1_valid_in;
   dq_pkg::meta_type  s1_meta_ff, s1_meta_in;

   logic                      out_valid_ff, out_valid_in;
   logic [dq_pkg::WORD_W-1:0] out_word_ff, out_word_in;
   dq_pkg::status_type        out_status_ff, out_status_in;
   logic [dq_pkg::OCC_W-1:0]  out_occ_ff, out_occ_in;

   dq_pkg::op_type   op;
   logic             accept, s1_move, is_push, full, empty;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_addr, front_prev, front_next, rear_prev, rear_next;

   assign op      = dq_pkg::op_type'(req_tuser);
   assign is_push = (op == dq_pkg::OP_PUSH_FRONT) || (op == dq_pkg::OP_PUSH_REAR);
   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign rear_prev  = (rear_ff == '0) ? LAST_IDX : rear_ff - 1'b1;
   assign rear_next  = (rear_ff == LAST_IDX) ? '0 : rear_ff + 1'b1;

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = front_ff;
      s1_meta_in.pop_ok = 1'b0;
      s1_meta_in.status = dq_pkg::ST_OK;
      if (accept) begin
         case (op)
            dq_pkg::OP_PUSH_FRONT: begin
               if (!full) begin
                  front_in = front_prev;
                  mem_addr = front_prev;
                  mem_we   = 1'b1;
               end
            end
            dq_pkg::OP_PUSH_REAR: begin
               if (!full) begin
                  rear_in  = rear_next;
                  mem_addr = rear_ff;
                  mem_we   = 1'b1;
               end
            end
            dq_pkg::OP_POP_FRONT: begin
               if (!empty) begin
                  front_in = front_next;
                  mem_addr = front_ff;
                  mem_re   = 1'b1;
               end
            end
            dq_pkg::OP_POP_REAR: begin
               if (!empty) begin
                  rear_in  = rear_prev;
                  mem_addr = rear_prev;
                  mem_re   = 1'b1;
               end
            end
            default: begin
               mem_addr = front_ff;
            end
         endcase
         if (is_push && full) begin
            s1_meta_in.status = dq_pkg::ST_FULL;
         end else if (!is_push && empty) begin
            s1_meta_in.status = dq_pkg::ST_EMPTY;
         end else if (is_push) begin
            count_in = count_ff + 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
         s1_meta_in.pop_ok = mem_re;
      end
      s1_meta_in.occupancy = dq_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_tdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   assign s1_valid_in   = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in  = s1_move ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);
   assign out_word_in   = s1_meta_ff.pop_ok ? rd_ff : '0;
   assign out_status_in = s1_meta_ff.status;
   assign out_occ_in    = s1_meta_ff.occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_move) begin
         out_word_ff   <= out_word_in;
         out_status_ff <= out_status_in;
         out_occ_ff    <= out_occ_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_occ_ff, out_word_ff};
   assign rsp_tuser  = out_status_ff;

`include "double_ended_queue_macros.svh"

   `DQ_ASSERT_ALWAYS(a_count_range, count_ff <= FULL_CNT, "entry count above depth")
   `DQ_ASSERT_IMPL(a_empty_aligned, count_ff == '0, front_ff == rear_ff, "empty queue with split indices")
   `DQ_ASSERT_NEXT(a_full_push_holds, accept && is_push && full, $stable(count_ff) && $stable(front_ff) && $stable(rear_ff), "push into full queue changed state")
   `DQ_ASSERT_IMPL(a_fail_no_word, rsp_tvalid && (rsp_tuser != dq_pkg::ST_OK), rsp_tdata[31:0] == '0, "failed operation returned a word")
   `DQ_ASSERT_IMPL(a_no_overrun, s1_valid_ff && !s1_move, !req_tready, "middle stage overwritten while stalled")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for double_ended_queue: directed table, then biased random traffic
// predicts results with its own circular-buffer deque model; typed rows use the table
// depends on dq_pkg and the double_ended_queue rtl

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int SLOT_W      = $clog2(DEPTH);
   localparam int RAND_ITEMS  = 1300;
   localparam int PHASE_LEN   = 100;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [dq_pkg::WORD_W-1:0] removed;
      dq_pkg::status_type        status;
      logic [dq_pkg::OCC_W-1:0]  occupancy;
   } deque_result_type;

   typedef struct packed {
      dq_pkg::op_type            op;
      logic [dq_pkg::WORD_W-1:0] word;
      logic                      typed;
      deque_result_type          want;
   } stim_row_type;

   localparam int ROWS = 18;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;

   logic [dq_pkg::WORD_W-1:0] slot_word [DEPTH];
   logic [SLOT_W-1:0]         head_slot;
   logic [SLOT_W-1:0]         tail_slot;
   logic [dq_pkg::OCC_W-1:0]  held_count;

   deque_result_type  pending_results [$];
   stim_row_type      directed [ROWS];
   int                mismatch_count = 0;
   int                items_sent = 0;
   int                cycle_count = 0;
   int                stall_left = 0;
   logic              calm = 1'b0;
   logic              hold_off = 1'b0;

   double_ended_queue #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** double_ended_queue: FAILED **");
         $finish;
      end
   end

   function automatic deque_result_type predict_deque(input dq_pkg::op_type op,
                                                      input logic [dq_pkg::WORD_W-1:0] word);
      deque_result_type r;
      r.removed = '0;
      r.status  = dq_pkg::ST_OK;
      if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_REAR) begin
         if (held_count == DEPTH) begin
            r.status = dq_pkg::ST_FULL;
         end else if (op == dq_pkg::OP_PUSH_FRONT) begin
            head_slot = head_slot - 1'b1;
            slot_word[head_slot] = word;
            held_count++;
         end else begin
            slot_word[tail_slot] = word;
            tail_slot = tail_slot + 1'b1;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = dq_pkg::ST_EMPTY;
         end else if (op == dq_pkg::OP_POP_FRONT) begin
            r.removed = slot_word[head_slot];
            head_slot = head_slot + 1'b1;
            held_count--;
         end else begin
            tail_slot = tail_slot - 1'b1;
            r.removed = slot_word[tail_slot];
            held_count--;
         end
      end
      r.occupancy = held_count;
      return r;
   endfunction

   task automatic offer_item(input dq_pkg::op_type op,
                             input logic [dq_pkg::WORD_W-1:0] word,
                             input logic typed, input deque_result_type want);
      int               gap;
      deque_result_type predicted;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predicted = predict_deque(op, word);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   function automatic logic [dq_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // response side: random stall after each item outside calm phases, long hold-off on request
   always @(posedge clock) begin
      deque_result_type want;
      deque_result_type seen;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.removed   = rsp_tdata[31:0];
            seen.occupancy = rsp_tdata[36:32];
            seen.status    = dq_pkg::status_type'(rsp_tuser);
            if (pending_results.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("unexpected item: removed %h status %0d occupancy %0d",
                           seen.removed, seen.status, seen.occupancy);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (seen !== want) begin
                  if (mismatch_count < REPORT_MAX)
                     $display("mismatch: removed %h/%h status %0d/%0d occupancy %0d/%0d",
                              want.removed, seen.removed, want.status, seen.status,
                              want.occupancy, seen.occupancy);
                  mismatch_count++;
               end
            end
            stall_left = calm ? 0 : $urandom_range(0, 11);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0) && !hold_off;
      end
   end

   // receiver hold-off so the block backs up and stalls req
   initial begin
      wait (items_sent >= 500);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      int               bias;
      int               phase;
      dq_pkg::op_type   op;
      deque_result_type none;

      none = '0;
      directed = '{
         '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 5'd0}},
         '{dq_pkg::OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 5'd0}},
         '{dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0, dq_pkg::ST_OK,    5'd1}},
         '{dq_pkg::OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, '{32'h0, dq_pkg::ST_OK,    5'd2}},
         '{dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_PUSH_REAR,  32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_REAR,   32'h1234_5678, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
           '{32'h8000_0000, dq_pkg::ST_OK, 5'd1}},
         '{dq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b1,
           '{32'h7FFF_FFFF, dq_pkg::ST_OK, 5'd0}},
         '{dq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 5'd0}},
         '{dq_pkg::OP_PUSH_REAR,  32'h5555_5555, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b0, '{32'h0, dq_pkg::ST_OK,    5'd0}},
         '{dq_pkg::OP_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'h0, dq_pkg::ST_EMPTY, 5'd0}}
      };

      head_slot  = '0;
      tail_slot  = '0;
      held_count = '0;
      foreach (slot_word[i]) slot_word[i] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         offer_item(directed[i].op, directed[i].word, directed[i].typed, directed[i].want);

      // phases cycle through fill-heavy, balanced and drain-heavy traffic
      for (int n = 0; n < RAND_ITEMS; n++) begin
         phase = n / PHASE_LEN;
         if (n % PHASE_LEN == 0)
            calm <= (phase % 4 == 3);
         case (phase % 5)
            0: bias = 85;
            1: bias = 50;
            2: bias = 15;
            3: bias = 95;
            default: bias = 5;
         endcase
         if ($urandom_range(0, 99) < bias)
            op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_REAR : dq_pkg::OP_PUSH_FRONT;
         else
            op = $urandom_range(0, 1) ? dq_pkg::OP_POP_REAR : dq_pkg::OP_POP_FRONT;
         offer_item(op, random_word(), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** double_ended_queue: PASSED **");
      end else begin
         $display("** double_ended_queue: FAILED **");
      end
      $finish;
   end

endmodule
